// ----- src/hlt_pkg.sv -----
package hlt_pkg;

  // Default depth of the trailing whitespace store
  localparam int PendingWsMaxDefault = 16;

  // Token kinds carried on the result stream
  typedef enum logic [2:0] {
    KIND_NAME_BYTE  = 3'd0,
    KIND_VALUE_BYTE = 3'd1,
    KIND_NAME_END   = 3'd2,
    KIND_HEADER_END = 3'd3,
    KIND_BLOCK_END  = 3'd4,
    KIND_ERROR      = 3'd5
  } kind_e;

  // Commands from the classifier to the emitter
  typedef enum logic {
    OP_PUSH = 1'b0,  // hold one whitespace byte
    OP_EMIT = 1'b1   // emit one token, clearing the store
  } op_e;

  typedef struct packed {
    op_e         op;
    kind_e       kind;
    logic [7:0]  data;
    logic        flush;  // release held whitespace before the token
  } cmd_t;

endpackage

// ----- src/hlt_front.sv -----
module hlt_front import hlt_pkg::*; #(
  parameter int PendingWsMax = PendingWsMaxDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic in_eoi_i,
  output logic cmd_valid_o,
  input  logic cmd_ready_i,
  output cmd_t cmd_o
);

  localparam int CntW = $clog2(PendingWsMax + 1);

  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharLf    = 8'h0A;

  typedef enum logic [1:0] {
    PH_LINE  = 2'd0,
    PH_NAME  = 2'd1,
    PH_VALUE = 2'd2
  } phase_e;

  phase_e phase_q, phase_d;
  logic seen_q, seen_d;
  logic [CntW-1:0] hcnt_q, hcnt_d;
  logic cmd_gen;
  logic is_ws;
  logic accept;

  assign in_ready_o  = cmd_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign cmd_valid_o = accept && cmd_gen;

  assign is_ws = (in_byte_i == 8'h20) || (in_byte_i == 8'h09) ||
                 (in_byte_i == 8'h0B) || (in_byte_i == 8'h0C);

  // Classify the byte and work out the command and next state
  always_comb begin
    phase_d = phase_q;
    seen_d  = seen_q;
    hcnt_d  = hcnt_q;
    cmd_gen = 1'b0;
    cmd_o   = '{op: OP_EMIT, kind: KIND_ERROR, data: 8'h00, flush: 1'b0};
    if (in_eoi_i) begin
      cmd_gen = 1'b1;
      phase_d = PH_LINE;
      seen_d  = 1'b0;
      hcnt_d  = '0;
    end else if (in_byte_i == CharCr) begin
      // drop carriage returns
    end else if (in_byte_i == CharLf) begin
      cmd_gen = 1'b1;
      case (phase_q)
        PH_NAME:  cmd_o.kind = KIND_ERROR;
        PH_VALUE: cmd_o.kind = KIND_HEADER_END;
        default:  cmd_o.kind = KIND_BLOCK_END;
      endcase
      phase_d = PH_LINE;
      seen_d  = 1'b0;
      hcnt_d  = '0;
    end else if (phase_q != PH_VALUE && in_byte_i == CharColon) begin
      cmd_gen    = 1'b1;
      cmd_o.kind = KIND_NAME_END;
      phase_d    = PH_VALUE;
      seen_d     = 1'b0;
      hcnt_d     = '0;
    end else begin
      cmd_o.kind = (phase_q == PH_VALUE) ? KIND_VALUE_BYTE : KIND_NAME_BYTE;
      if (phase_q != PH_VALUE) phase_d = PH_NAME;
      if (is_ws) begin
        if (seen_q) begin
          cmd_gen = 1'b1;
          if (hcnt_q >= CntW'(PendingWsMax)) begin
            cmd_o.kind = KIND_ERROR;
            phase_d    = PH_LINE;
            seen_d     = 1'b0;
            hcnt_d     = '0;
          end else begin
            cmd_o.op   = OP_PUSH;
            cmd_o.data = in_byte_i;
            hcnt_d     = hcnt_q + CntW'(1);
          end
        end
      end else begin
        cmd_gen     = 1'b1;
        cmd_o.data  = in_byte_i;
        cmd_o.flush = 1'b1;
        hcnt_d      = '0;
        seen_d      = 1'b1;
      end
    end
  end

  // Advance the line state on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LINE;
      seen_q  <= 1'b0;
      hcnt_q  <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      seen_q  <= seen_d;
      hcnt_q  <= hcnt_d;
    end
  end

endmodule

// ----- src/hlt_queue.sv -----
module hlt_queue import hlt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_data_o
);

  localparam int Depth = 2;
  localparam int PtrW  = $clog2(Depth);

  cmd_t entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0] fill_q;
  logic do_push, do_pop;

  assign push_ready_o = (fill_q != (PtrW + 1)'(Depth));
  assign pop_valid_o  = (fill_q != '0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // Store requests
  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_ptr_q] <= push_data_i;
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + PtrW'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + PtrW'(1);
      if (do_push && !do_pop)      fill_q <= fill_q + (PtrW + 1)'(1);
      else if (do_pop && !do_push) fill_q <= fill_q - (PtrW + 1)'(1);
    end
  end

endmodule

// ----- src/hlt_back.sv -----
module hlt_back import hlt_pkg::*; #(
  parameter int PendingWsMax = PendingWsMaxDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  output logic cmd_ready_o,
  input  cmd_t cmd_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output kind_e out_kind_o,
  output logic [7:0] out_byte_o,
  output logic out_last_o
);

  localparam int CntW = $clog2(PendingWsMax + 1);
  localparam int IdxW = (PendingWsMax > 1) ? $clog2(PendingWsMax) : 1;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_FLUSH = 2'd1,
    BK_TAIL  = 2'd2
  } state_e;

  state_e state_q;
  logic [CntW-1:0] cnt_q;
  logic [IdxW-1:0] idx_q, idx_d;
  kind_e kind_q;
  logic [7:0] byte_q;
  logic out_valid_q, out_last_q;
  kind_e out_kind_q;
  logic [7:0] out_byte_q;
  logic [7:0] mem_q [PendingWsMax];
  logic [7:0] rdata_q;
  logic can_load, last_held, do_write;
  logic do_load;

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

  assign can_load  = !out_valid_q || out_ready_i;
  assign last_held = (CntW'(idx_q) + CntW'(1)) == cnt_q;
  assign do_write  = (state_q == BK_IDLE) && cmd_valid_i && (cmd_i.op == OP_PUSH);

  // Load the output register with a plain token, a held byte or the tail token
  assign do_load = ((state_q == BK_IDLE) && cmd_valid_i && cmd_ready_o &&
                    (cmd_i.op == OP_EMIT) && !(cmd_i.flush && cnt_q != '0)) ||
                   ((state_q == BK_FLUSH || state_q == BK_TAIL) && can_load);

  // Pick the request handshake and the next read address
  always_comb begin
    cmd_ready_o = 1'b0;
    idx_d       = idx_q;
    case (state_q)
      BK_IDLE: begin
        idx_d = '0;
        if (cmd_i.op == OP_PUSH) cmd_ready_o = 1'b1;
        else if (cmd_i.flush && cnt_q != '0) cmd_ready_o = 1'b1;
        else cmd_ready_o = can_load;
      end
      BK_FLUSH: begin
        if (can_load && !last_held) idx_d = idx_q + IdxW'(1);
      end
      default: idx_d = idx_q;
    endcase
  end

  // Whitespace store with registered read
  always_ff @(posedge clk_i) begin
    if (do_write) mem_q[cnt_q[IdxW-1:0]] <= cmd_i.data;
    rdata_q <= mem_q[idx_d];
  end

  // Sequence tokens into the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      kind_q      <= KIND_ERROR;
      byte_q      <= '0;
      out_valid_q <= 1'b0;
      out_kind_q  <= KIND_ERROR;
      out_byte_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (do_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        BK_IDLE: begin
          if (cmd_valid_i && cmd_ready_o) begin
            if (cmd_i.op == OP_PUSH) begin
              cnt_q <= cnt_q + CntW'(1);
            end else if (cmd_i.flush && cnt_q != '0) begin
              kind_q  <= cmd_i.kind;
              byte_q  <= cmd_i.data;
              state_q <= BK_FLUSH;
            end else begin
              out_kind_q  <= cmd_i.kind;
              out_byte_q  <= cmd_i.data;
              out_last_q  <= 1'b1;
              cnt_q       <= '0;
            end
          end
        end
        BK_FLUSH: begin
          if (can_load) begin
            out_kind_q  <= kind_q;
            out_byte_q  <= rdata_q;
            out_last_q  <= 1'b0;
            if (last_held) state_q <= BK_TAIL;
          end
        end
        BK_TAIL: begin
          if (can_load) begin
            out_kind_q  <= kind_q;
            out_byte_q  <= byte_q;
            out_last_q  <= 1'b1;
            cnt_q       <= '0;
            state_q     <= BK_IDLE;
          end
        end
        default: state_q <= BK_IDLE;
      endcase
    end
  end

endmodule

// ----- src/header_line_tokenizer.sv -----
// Channel   | Direction | tdata              | tuser    | tlast
// s_axis    | in        | [7:0] in_byte      | -        | end_of_input
// m_axis    | out       | [7:0] out_byte     | [2:0] kind | last_of_run
//
// The classifier takes one byte per cycle while the two-entry request queue has room.
// The emitter stores a held whitespace byte or loads a plain token directly; a content
// byte first sends the held bytes from the store (read is registered), then itself.
// Reset clears line state, counts and the queue; the whitespace store needs no clearing.
// A stalled result holds the emitter, which in turn fills the queue and drops tready.
module header_line_tokenizer import hlt_pkg::*; #(
  parameter int PendingWsMax = PendingWsMaxDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  logic s_axis_tlast_i,         // end_of_input
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic [2:0] m_axis_tuser_o,   // [2:0] kind
  output logic m_axis_tlast_o          // last_of_run
);

  cmd_t front_cmd, back_cmd;
  logic front_valid, front_ready;
  logic back_valid, back_ready;
  kind_e out_kind;

  // Classify incoming bytes
  hlt_front #(.PendingWsMax(PendingWsMax)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_byte_i   (s_axis_tdata_i),
    .in_eoi_i    (s_axis_tlast_i),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready),
    .cmd_o       (front_cmd)
  );

  // Decouple classifier from emitter
  hlt_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_data_i  (front_cmd),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_data_o   (back_cmd)
  );

  // Emit tokens and release held whitespace
  hlt_back #(.PendingWsMax(PendingWsMax)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (back_valid),
    .cmd_ready_o (back_ready),
    .cmd_i       (back_cmd),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_kind_o  (out_kind),
    .out_byte_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tuser_o = out_kind;

`ifndef SYNTHESIS
  // Markers carry no byte and always close their run
  a_marker_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == KIND_NAME_END || m_axis_tuser_o == KIND_HEADER_END ||
      m_axis_tuser_o == KIND_BLOCK_END || m_axis_tuser_o == KIND_ERROR)
    |-> m_axis_tlast_o && m_axis_tdata_o == 8'h00)
    else $error("marker token without last or with a byte");

  // Only byte tokens may be followed within the same run
  a_run_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o
    |-> m_axis_tuser_o == KIND_NAME_BYTE || m_axis_tuser_o == KIND_VALUE_BYTE)
    else $error("non-byte token inside a run");

  // A flush run continues in the next cycle with the same kind
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o
    |=> m_axis_tvalid_o && m_axis_tuser_o == $past(m_axis_tuser_o))
    else $error("flush run broken");
`endif

endmodule
